FILE: design/flptm_pkg.sv
// Package for the four-level page table mapper: pool sizing, status codes,
// microcode step numbers, control word layout and the microcode ROM.
// No dependencies.
package flptm_pkg;

    // Table frame pool
    localparam int TABLE_FRAMES = 64;
    localparam int IDX_W        = 9;
    localparam int OFFSET_W     = 12;
    localparam int FRAME_W      = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NEXT_W       = $clog2(TABLE_FRAMES + 1);
    localparam int SLOT_W       = FRAME_W + IDX_W;
    localparam int SLOTS        = TABLE_FRAMES * (1 << IDX_W);
    localparam int ENTRY_W      = 64;
    localparam int VA_W         = 48;
    localparam int PA_W         = 52;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FRAMES  = 2'd1;
    localparam logic [1:0] ST_ALREADY    = 2'd2;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

    // Microcode step numbers
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] S_CLEAR  = 5'd0;
    localparam logic [PC_W-1:0] S_IDLE   = 5'd1;
    localparam logic [PC_W-1:0] S_READ   = 5'd2;
    localparam logic [PC_W-1:0] S_TEST   = 5'd3;
    localparam logic [PC_W-1:0] S_PRES   = 5'd4;
    localparam logic [PC_W-1:0] S_MISS   = 5'd5;
    localparam logic [PC_W-1:0] S_ACHK   = 5'd6;
    localparam logic [PC_W-1:0] S_ALLOC  = 5'd7;
    localparam logic [PC_W-1:0] S_FOLLOW = 5'd8;
    localparam logic [PC_W-1:0] S_FPTR   = 5'd9;
    localparam logic [PC_W-1:0] S_LEAF   = 5'd10;
    localparam logic [PC_W-1:0] S_LEAFP  = 5'd11;
    localparam logic [PC_W-1:0] S_LEAFA  = 5'd12;
    localparam logic [PC_W-1:0] S_MAPWR  = 5'd13;
    localparam logic [PC_W-1:0] S_UNMWR  = 5'd14;
    localparam logic [PC_W-1:0] S_FNF    = 5'd15;
    localparam logic [PC_W-1:0] S_FNM    = 5'd16;
    localparam logic [PC_W-1:0] S_FAM    = 5'd17;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_ALLOC,
        OP_FOLLOW,
        OP_MAP_WR,
        OP_UNMAP_WR,
        OP_REP_NF,
        OP_REP_NM,
        OP_REP_AM
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_START,
        C_CLR_LAST,
        C_LEAF,
        C_PRESENT,
        C_UNMAP,
        C_POOL_EMPTY,
        C_PTR_BAD
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] t_true;
        logic [PC_W-1:0] t_false;
    } t_uword;

    function automatic t_uword uc_word(input t_op op, input t_cond cond,
                                       input logic [PC_W-1:0] t_true,
                                       input logic [PC_W-1:0] t_false);
        t_uword w;
        w.op      = op;
        w.cond    = cond;
        w.t_true  = t_true;
        w.t_false = t_false;
        return w;
    endfunction

    // Microcode ROM: one control word per step
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            S_CLEAR:  w = uc_word(OP_CLEAR,    C_CLR_LAST,   S_IDLE,   S_CLEAR);
            S_IDLE:   w = uc_word(OP_LOAD,     C_START,      S_READ,   S_IDLE);
            S_READ:   w = uc_word(OP_READ,     C_ALWAYS,     S_TEST,   S_TEST);
            S_TEST:   w = uc_word(OP_NOP,      C_LEAF,       S_LEAF,   S_PRES);
            S_PRES:   w = uc_word(OP_NOP,      C_PRESENT,    S_FOLLOW, S_MISS);
            S_MISS:   w = uc_word(OP_NOP,      C_UNMAP,      S_FNM,    S_ACHK);
            S_ACHK:   w = uc_word(OP_NOP,      C_POOL_EMPTY, S_FNF,    S_ALLOC);
            S_ALLOC:  w = uc_word(OP_ALLOC,    C_ALWAYS,     S_FOLLOW, S_FOLLOW);
            S_FOLLOW: w = uc_word(OP_FOLLOW,   C_PTR_BAD,    S_FPTR,   S_READ);
            S_FPTR:   w = uc_word(OP_NOP,      C_UNMAP,      S_FNM,    S_FNF);
            S_LEAF:   w = uc_word(OP_NOP,      C_PRESENT,    S_LEAFP,  S_LEAFA);
            S_LEAFP:  w = uc_word(OP_NOP,      C_UNMAP,      S_UNMWR,  S_FAM);
            S_LEAFA:  w = uc_word(OP_NOP,      C_UNMAP,      S_FNM,    S_MAPWR);
            S_MAPWR:  w = uc_word(OP_MAP_WR,   C_ALWAYS,     S_IDLE,   S_IDLE);
            S_UNMWR:  w = uc_word(OP_UNMAP_WR, C_ALWAYS,     S_IDLE,   S_IDLE);
            S_FNF:    w = uc_word(OP_REP_NF,   C_ALWAYS,     S_IDLE,   S_IDLE);
            S_FNM:    w = uc_word(OP_REP_NM,   C_ALWAYS,     S_IDLE,   S_IDLE);
            S_FAM:    w = uc_word(OP_REP_AM,   C_ALWAYS,     S_IDLE,   S_IDLE);
            default:  w = uc_word(OP_NOP,      C_ALWAYS,     S_IDLE,   S_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: design/four_level_page_table_mapper_unit.sv
// Four-level page table mapper: microcoded walker over an internal table store.
// Depends on flptm_pkg (constants, status codes, microcode ROM).
//
// Maps or unmaps one 4 KiB page per request in a four-level radix page table
// held in an internal pool of TABLE_FRAMES frames of 512 64-bit entries;
// frame 0 is the root. After reset the block runs a clearing pass over the
// whole store, one entry per cycle (TABLE_FRAMES * 512 = 32768 entries), and
// holds busy high throughout. A request is taken when start is high and busy
// is low; busy then stays high until the result beat. The walk is driven by a
// microcode sequencer over a single-port table store: an upper level that is
// present costs four steps (read, level test, present test, follow), a missing
// one three more (mode test, pool check, allocate and write), and the leaf
// five (read, level test, present test, mode test, then write or report).
// A request therefore takes 5 to 26 steps, and its result beat is registered
// from its last step; the next request can be taken at the edge that ends
// the beat. The result beat (o_status with o_valid) lasts exactly one cycle
// and cannot be held off, so the receiver must take it when o_valid is high.
module four_level_page_table_mapper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [flptm_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [flptm_pkg::PA_W-1:0]    i_phys_addr,
    input  logic [flptm_pkg::ENTRY_W-1:0] i_entry_flags,
    output logic                          o_valid,
    output logic [1:0]                    o_status
);

    // Sequencer and control state
    logic [flptm_pkg::PC_W-1:0]    r_pc;
    logic [flptm_pkg::SLOT_W-1:0]  r_clr_addr;
    logic [flptm_pkg::NEXT_W-1:0]  r_next_free;
    logic [1:0]                    r_level;
    logic                          r_valid;
    logic [1:0]                    r_status;

    // Request and walk payload
    logic                           r_mode;
    logic [flptm_pkg::VA_W-1:0]     r_va;
    logic [flptm_pkg::PA_W-1:0]     r_pa;
    logic [flptm_pkg::ENTRY_W-1:0]  r_flags;
    logic [flptm_pkg::FRAME_W-1:0]  r_frame;
    logic [flptm_pkg::ENTRY_W-1:0]  r_rdata;

    // Table store
    logic [flptm_pkg::ENTRY_W-1:0] mem [flptm_pkg::SLOTS];

    flptm_pkg::t_uword             uw;
    logic                          cond_hit;
    logic [flptm_pkg::PC_W-1:0]    n_pc;
    logic [flptm_pkg::IDX_W-1:0]   lvl_idx;
    logic [flptm_pkg::SLOT_W-1:0]  slot;
    logic                          present;
    logic                          ptr_bad;
    logic                          pool_empty;
    logic [flptm_pkg::ENTRY_W-1:0] new_entry;
    logic [flptm_pkg::ENTRY_W-1:0] leaf_entry;
    logic                          mem_we;
    logic [flptm_pkg::SLOT_W-1:0]  mem_waddr;
    logic [flptm_pkg::ENTRY_W-1:0] mem_wdata;

    assign uw = flptm_pkg::uc_rom(r_pc);

    // Index of the current level: bits 39, 30, 21, 12 of the virtual address
    always_comb begin
        unique case (r_level)
            2'd0:    lvl_idx = r_va[39 +: flptm_pkg::IDX_W];
            2'd1:    lvl_idx = r_va[30 +: flptm_pkg::IDX_W];
            2'd2:    lvl_idx = r_va[21 +: flptm_pkg::IDX_W];
            default: lvl_idx = r_va[12 +: flptm_pkg::IDX_W];
        endcase
    end

    assign slot       = {r_frame, lvl_idx};
    assign present    = r_rdata[0];
    // A pointer naming a frame beyond the pool stops the walk
    assign ptr_bad    = (r_rdata[flptm_pkg::ENTRY_W-1:flptm_pkg::OFFSET_W]
                         >= (flptm_pkg::ENTRY_W - flptm_pkg::OFFSET_W)'(flptm_pkg::TABLE_FRAMES));
    assign pool_empty = (r_next_free == flptm_pkg::NEXT_W'(flptm_pkg::TABLE_FRAMES));

    assign new_entry  = {{(flptm_pkg::ENTRY_W - flptm_pkg::OFFSET_W - flptm_pkg::NEXT_W){1'b0}},
                         r_next_free, {flptm_pkg::OFFSET_W{1'b0}}}
                        | r_flags | flptm_pkg::ENTRY_W'(1);
    assign leaf_entry = {{(flptm_pkg::ENTRY_W - flptm_pkg::PA_W){1'b0}},
                         r_pa[flptm_pkg::PA_W-1:flptm_pkg::OFFSET_W],
                         {flptm_pkg::OFFSET_W{1'b0}}}
                        | r_flags | flptm_pkg::ENTRY_W'(1);

    // Branch condition select
    always_comb begin
        unique case (uw.cond)
            flptm_pkg::C_ALWAYS:     cond_hit = 1'b1;
            flptm_pkg::C_START:      cond_hit = start;
            flptm_pkg::C_CLR_LAST:   cond_hit = (r_clr_addr ==
                                                 flptm_pkg::SLOT_W'(flptm_pkg::SLOTS - 1));
            flptm_pkg::C_LEAF:       cond_hit = (r_level == 2'd3);
            flptm_pkg::C_PRESENT:    cond_hit = present;
            flptm_pkg::C_UNMAP:      cond_hit = r_mode;
            flptm_pkg::C_POOL_EMPTY: cond_hit = pool_empty;
            flptm_pkg::C_PTR_BAD:    cond_hit = ptr_bad;
            default:                 cond_hit = 1'b0;
        endcase
    end

    assign n_pc = cond_hit ? uw.t_true : uw.t_false;

    // Store write port: clear pass, new level, leaf write, leaf zero
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot;
        mem_wdata = '0;
        unique case (uw.op)
            flptm_pkg::OP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            flptm_pkg::OP_ALLOC: begin
                mem_we    = ~pool_empty;
                mem_wdata = new_entry;
            end
            flptm_pkg::OP_MAP_WR: begin
                mem_we    = 1'b1;
                mem_wdata = leaf_entry;
            end
            flptm_pkg::OP_UNMAP_WR: begin
                mem_we    = 1'b1;
            end
            default: begin
                mem_we    = 1'b0;
            end
        endcase
    end

    // Table store and its registered read; a freshly allocated entry is
    // taken straight into the read register so the walk can follow it
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (uw.op == flptm_pkg::OP_READ) begin
            r_rdata <= mem[slot];
        end else if (uw.op == flptm_pkg::OP_ALLOC) begin
            r_rdata <= new_entry;
        end
    end

    // Request payload: capture on acceptance
    always_ff @(posedge i_clk) begin
        if (uw.op == flptm_pkg::OP_LOAD && start) begin
            r_mode  <= i_mode;
            r_va    <= i_virt_addr;
            r_pa    <= i_phys_addr;
            r_flags <= i_entry_flags;
        end
    end

    // Sequencer, walk position and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= flptm_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= flptm_pkg::NEXT_W'(1);
            r_level     <= 2'd0;
            r_frame     <= '0;
            r_valid     <= 1'b0;
            r_status    <= flptm_pkg::ST_OK;
        end else begin
            r_pc    <= n_pc;
            r_valid <= 1'b0;
            unique case (uw.op)
                flptm_pkg::OP_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                flptm_pkg::OP_LOAD: begin
                    // Start every walk at the root
                    r_level <= 2'd0;
                    r_frame <= '0;
                end
                flptm_pkg::OP_ALLOC: begin
                    r_next_free <= r_next_free + 1'b1;
                end
                flptm_pkg::OP_FOLLOW: begin
                    // Advance one level; a bad pointer is dropped by the jump
                    r_frame <= r_rdata[flptm_pkg::OFFSET_W +: flptm_pkg::FRAME_W];
                    r_level <= r_level + 1'b1;
                end
                flptm_pkg::OP_MAP_WR, flptm_pkg::OP_UNMAP_WR: begin
                    r_valid  <= 1'b1;
                    r_status <= flptm_pkg::ST_OK;
                end
                flptm_pkg::OP_REP_NF: begin
                    r_valid  <= 1'b1;
                    r_status <= flptm_pkg::ST_NO_FRAMES;
                end
                flptm_pkg::OP_REP_NM: begin
                    r_valid  <= 1'b1;
                    r_status <= flptm_pkg::ST_NOT_MAPPED;
                end
                flptm_pkg::OP_REP_AM: begin
                    r_valid  <= 1'b1;
                    r_status <= flptm_pkg::ST_ALREADY;
                end
                default: begin
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign busy     = (r_pc != flptm_pkg::S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule
